/* rtl/bba_pkg.sv */
// Shared types and constants for the buddy block allocator.
package bba_pkg;

  localparam int OP_W      = 2;
  localparam int SIZE_W    = 32;
  localparam int OFFSET_W  = 20;
  localparam int STATUS_W  = 2;
  localparam int GLEVEL_W  = 4;
  localparam int UNITS_W   = 11;
  localparam int POOL_W    = 4;
  localparam int LVL_BITS  = 5;
  localparam int WORD_BITS = 32;
  localparam int WORD_LOG  = 5;

  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TOO_BIG  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NO_BLOCK = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_FREE = 2'd3;

  localparam logic [POOL_W-1:0] POOL_LEVEL_RST = 4'd10;

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_SPLIT_RD,
    S_SPLIT_CHK,
    S_REC,
    S_FREE_RD,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_CHK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic                too_big;
    logic [LVL_BITS-1:0] want;
  } lvl_info_t;

endpackage

/* rtl/bba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

/* rtl/bba_lvl_calc.sv */
// Request size to block level rounding and pool size check.
module bba_lvl_calc #(
  parameter int MIN_BLOCK_BYTES = 1024,
  parameter int TOP_LEVEL       = 10
) (
  input  logic [bba_pkg::SIZE_W-1:0]   size_bytes,
  input  logic [bba_pkg::LVL_BITS-1:0] active_level,
  output bba_pkg::lvl_info_t           info
);
  import bba_pkg::*;

  logic [63:0]         blk_bytes;
  logic [63:0]         pool_bytes;
  logic [LVL_BITS-1:0] cnt;

  always_comb begin
    cnt = '0;
    blk_bytes = '0;
    for (int l = 0; l <= TOP_LEVEL; l++) begin
      blk_bytes = 64'(MIN_BLOCK_BYTES) << l;
      if ((LVL_BITS'(l) < active_level) && (blk_bytes < 64'(size_bytes))) begin
        cnt = cnt + LVL_BITS'(1);
      end
    end
    pool_bytes   = 64'(MIN_BLOCK_BYTES) << active_level;
    info.too_big = 64'(size_bytes) > pool_bytes;
    info.want    = cnt;
  end
endmodule

/* rtl/buddy_block_allocator.sv */
// Buddy block allocator: one operation at a time over free-map and record RAMs.
// Allocate: free-map rows are read and checked in turn, then each split level is read and written.
// Free: record read and check, then a free-map read and write per merge level; clear: clearing sweep.
// Free-map updates during allocate and free are read-modify-writes through registered-read RAMs.
// After reset the same clearing sweep runs, input held off.
// Configuration writes are taken at any time; pool_level applies on the next clear.
module buddy_block_allocator #(
  parameter int MIN_BLOCK_BYTES = 1024,
  parameter int TOP_LEVEL       = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,     // pool_level
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,     // size_bytes[31:0], block_offset[51:32]
  input  logic [1:0]  in_tuser,     // op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,    // granted_offset[19:0], granted_level[23:20],
                                    // allocated_units[34:24]
  output logic [1:0]  out_tuser     // status
);
  import bba_pkg::*;

  localparam int LOG_MIN  = $clog2(MIN_BLOCK_BYTES);
  localparam int NODE_W   = TOP_LEVEL + 1;
  localparam int ROW_W    = (NODE_W > WORD_LOG) ? NODE_W - WORD_LOG : 1;
  localparam int ROWS     = 1 << ROW_W;
  localparam int NIDX_W   = ROW_W + WORD_LOG;
  localparam int BW       = NIDX_W + 1;
  localparam int UNIT_W   = TOP_LEVEL;
  localparam int UNITS    = 1 << TOP_LEVEL;
  localparam int REC_W    = 1 + LVL_BITS;
  localparam int CNT_W    = TOP_LEVEL + 2;
  localparam int CLR_N    = (UNITS > ROWS) ? UNITS : ROWS;
  localparam int CLR_W    = $clog2(CLR_N) + 1;
  localparam logic [LVL_BITS-1:0] TOP_L   = LVL_BITS'(TOP_LEVEL);
  localparam logic [LVL_BITS-1:0] ACT_RST = (TOP_LEVEL < 10) ? LVL_BITS'(TOP_LEVEL)
                                                             : LVL_BITS'(10);

  function automatic logic [NIDX_W-1:0] node_of(input logic [LVL_BITS-1:0] l,
                                                input logic [UNIT_W-1:0] b);
    node_of = (NIDX_W'(1) << (TOP_L - l)) + NIDX_W'(b);
  endfunction

  function automatic logic [BW-1:0] lvl_base(input logic [LVL_BITS-1:0] l);
    lvl_base = BW'(1) << (TOP_L - l);
  endfunction

  state_t                state_r, state_nxt;
  logic [POOL_W-1:0]     pool_level_r;
  logic [LVL_BITS-1:0]   active_r, active_nxt;
  logic [LVL_BITS-1:0]   lvl_r, lvl_nxt;
  logic [LVL_BITS-1:0]   want_r, want_nxt;
  logic [UNIT_W-1:0]     blk_r, blk_nxt;
  logic [UNIT_W-1:0]     unit_r, unit_nxt;
  logic [ROW_W-1:0]      row_r, row_nxt;
  logic [CLR_W-1:0]      clr_r, clr_nxt;
  logic                  pend_r, pend_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [STATUS_W-1:0]   res_status_r, res_status_nxt;
  logic [OFFSET_W-1:0]   res_off_r, res_off_nxt;
  logic [GLEVEL_W-1:0]   res_lvl_r, res_lvl_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;
  logic [OFFSET_W-1:0]   out_off_r, out_off_nxt;
  logic [GLEVEL_W-1:0]   out_lvl_r, out_lvl_nxt;
  logic [UNITS_W-1:0]    out_units_r, out_units_nxt;

  logic                  fm_we;
  logic [ROW_W-1:0]      fm_waddr, fm_raddr;
  logic [WORD_BITS-1:0]  fm_wdata, fm_rdata;
  logic                  rec_we;
  logic [UNIT_W-1:0]     rec_waddr, rec_raddr;
  logic [REC_W-1:0]      rec_wdata, rec_rdata;

  lvl_info_t             info;
  logic [SIZE_W-1:0]     in_size;
  logic [OFFSET_W-1:0]   in_off;
  logic [OFFSET_W-1:0]   unit_wide;
  logic                  accept;

  logic [NIDX_W-1:0]     top_node, cand, mnode, snode, buddy;
  logic [BW-1:0]         base_w, hi_w, nbase_w, want_base;
  logic [WORD_BITS-1:0]  sel;
  logic [WORD_LOG-1:0]   pos;
  logic                  any;
  logic [UNIT_W-1:0]     unit_alloc;
  logic [LVL_BITS-1:0]   rec_lvl;

  assign in_size   = in_tdata[31:0];
  assign in_off    = in_tdata[51:32];
  assign unit_wide = in_off >> LOG_MIN;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  bba_lvl_calc #(
    .MIN_BLOCK_BYTES (MIN_BLOCK_BYTES),
    .TOP_LEVEL       (TOP_LEVEL)
  ) u_lvl_calc (
    .size_bytes   (in_size),
    .active_level (active_r),
    .info         (info)
  );

  bba_ram #(.WIDTH(WORD_BITS), .DEPTH(ROWS)) u_free_map (
    .clk   (clk),
    .we    (fm_we),
    .waddr (fm_waddr),
    .wdata (fm_wdata),
    .raddr (fm_raddr),
    .rdata (fm_rdata)
  );

  bba_ram #(.WIDTH(REC_W), .DEPTH(UNITS)) u_alloc_rec (
    .clk   (clk),
    .we    (rec_we),
    .waddr (rec_waddr),
    .wdata (rec_wdata),
    .raddr (rec_raddr),
    .rdata (rec_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      pool_level_r <= POOL_LEVEL_RST;
      active_r     <= ACT_RST;
      clr_r        <= '0;
      pend_r       <= 1'b0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      active_r     <= active_nxt;
      clr_r        <= clr_nxt;
      pend_r       <= pend_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        pool_level_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    lvl_r        <= lvl_nxt;
    want_r       <= want_nxt;
    blk_r        <= blk_nxt;
    unit_r       <= unit_nxt;
    row_r        <= row_nxt;
    res_status_r <= res_status_nxt;
    res_off_r    <= res_off_nxt;
    res_lvl_r    <= res_lvl_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_lvl_r    <= out_lvl_nxt;
    out_units_r  <= out_units_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    active_nxt     = active_r;
    lvl_nxt        = lvl_r;
    want_nxt       = want_r;
    blk_nxt        = blk_r;
    unit_nxt       = unit_r;
    row_nxt        = row_r;
    clr_nxt        = clr_r;
    pend_nxt       = pend_r;
    count_nxt      = count_r;
    res_status_nxt = res_status_r;
    res_off_nxt    = res_off_r;
    res_lvl_nxt    = res_lvl_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_lvl_nxt    = out_lvl_r;
    out_units_nxt  = out_units_r;

    fm_we     = 1'b0;
    fm_waddr  = row_r;
    fm_wdata  = fm_rdata;
    fm_raddr  = row_r;
    rec_we    = 1'b0;
    rec_waddr = unit_r;
    rec_wdata = '0;
    rec_raddr = unit_r;

    top_node   = node_of(active_r, '0);
    mnode      = node_of(lvl_r, blk_r);
    buddy      = mnode ^ NIDX_W'(1);
    snode      = node_of(lvl_r, blk_r + UNIT_W'(1));
    base_w     = lvl_base(lvl_r);
    hi_w       = (base_w << 1) - BW'(1);
    nbase_w    = lvl_base(lvl_r + LVL_BITS'(1));
    want_base  = lvl_base(info.want);
    unit_alloc = blk_r << want_r;
    rec_lvl    = rec_rdata[LVL_BITS-1:0];

    cand = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      cand   = {row_r, WORD_LOG'(i)};
      sel[i] = fm_rdata[i] && (BW'(cand) >= base_w) && (BW'(cand) <= hi_w);
    end
    any = |sel;
    pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (sel[i]) begin
        pos = WORD_LOG'(i);
      end
    end

    case (state_r)
      S_CLR: begin
        if (clr_r < CLR_W'(ROWS)) begin
          fm_we    = 1'b1;
          fm_waddr = clr_r[ROW_W-1:0];
          fm_wdata = '0;
          if (clr_r[ROW_W-1:0] == top_node[WORD_LOG +: ROW_W]) begin
            fm_wdata[top_node[WORD_LOG-1:0]] = 1'b1;
          end
        end
        if (clr_r < CLR_W'(UNITS)) begin
          rec_we    = 1'b1;
          rec_waddr = clr_r[UNIT_W-1:0];
          rec_wdata = '0;
        end
        clr_nxt = clr_r + CLR_W'(1);
        if (clr_r == CLR_W'(CLR_N - 1)) begin
          clr_nxt   = '0;
          state_nxt = pend_r ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          res_status_nxt = ST_OK;
          res_off_nxt    = '0;
          res_lvl_nxt    = '0;
          case (in_tuser)
            OP_ALLOC: begin
              if (info.too_big) begin
                res_status_nxt = ST_TOO_BIG;
                state_nxt      = S_DONE;
              end else begin
                want_nxt  = info.want;
                lvl_nxt   = info.want;
                row_nxt   = want_base[WORD_LOG +: ROW_W];
                state_nxt = S_SCAN_RD;
              end
            end
            OP_FREE: begin
              if ((|in_off[LOG_MIN-1:0]) || (|(unit_wide >> active_r))) begin
                res_status_nxt = ST_BAD_FREE;
                state_nxt      = S_DONE;
              end else begin
                unit_nxt  = UNIT_W'(unit_wide);
                state_nxt = S_FREE_RD;
              end
            end
            OP_CLEAR: begin
              active_nxt = ({1'b0, pool_level_r} > TOP_L) ? TOP_L
                                                          : LVL_BITS'(pool_level_r);
              count_nxt  = '0;
              clr_nxt    = '0;
              pend_nxt   = 1'b1;
              state_nxt  = S_CLR;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_SCAN_RD: begin
        fm_raddr  = row_r;
        state_nxt = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (any) begin
          fm_we         = 1'b1;
          fm_waddr      = row_r;
          fm_wdata      = fm_rdata;
          fm_wdata[pos] = 1'b0;
          blk_nxt = UNIT_W'(BW'({row_r, pos}) - base_w);
          if (lvl_r > want_r) begin
            lvl_nxt   = lvl_r - LVL_BITS'(1);
            blk_nxt   = UNIT_W'(BW'({row_r, pos}) - base_w) << 1;
            state_nxt = S_SPLIT_RD;
          end else begin
            state_nxt = S_REC;
          end
        end else if (row_r == hi_w[WORD_LOG +: ROW_W]) begin
          if (lvl_r == active_r) begin
            res_status_nxt = ST_NO_BLOCK;
            state_nxt      = S_DONE;
          end else begin
            lvl_nxt   = lvl_r + LVL_BITS'(1);
            row_nxt   = nbase_w[WORD_LOG +: ROW_W];
            state_nxt = S_SCAN_RD;
          end
        end else begin
          row_nxt   = row_r + ROW_W'(1);
          state_nxt = S_SCAN_RD;
        end
      end
      S_SPLIT_RD: begin
        fm_raddr  = snode[WORD_LOG +: ROW_W];
        state_nxt = S_SPLIT_CHK;
      end
      S_SPLIT_CHK: begin
        fm_we    = 1'b1;
        fm_waddr = snode[WORD_LOG +: ROW_W];
        fm_wdata = fm_rdata;
        fm_wdata[snode[WORD_LOG-1:0]] = 1'b1;
        if (lvl_r > want_r) begin
          lvl_nxt   = lvl_r - LVL_BITS'(1);
          blk_nxt   = blk_r << 1;
          state_nxt = S_SPLIT_RD;
        end else begin
          state_nxt = S_REC;
        end
      end
      S_REC: begin
        rec_we      = 1'b1;
        rec_waddr   = unit_alloc;
        rec_wdata   = {1'b1, want_r};
        count_nxt   = count_r + (CNT_W'(1) << want_r);
        res_off_nxt = OFFSET_W'(64'(unit_alloc) << LOG_MIN);
        res_lvl_nxt = GLEVEL_W'(want_r);
        state_nxt   = S_DONE;
      end
      S_FREE_RD: begin
        rec_raddr = unit_r;
        state_nxt = S_FREE_CHK;
      end
      S_FREE_CHK: begin
        if (!rec_rdata[REC_W-1] || (rec_lvl > active_r)) begin
          res_status_nxt = ST_BAD_FREE;
          state_nxt      = S_DONE;
        end else begin
          rec_we    = 1'b1;
          rec_waddr = unit_r;
          rec_wdata = '0;
          count_nxt = count_r - (CNT_W'(1) << rec_lvl);
          lvl_nxt   = rec_lvl;
          blk_nxt   = unit_r >> rec_lvl;
          state_nxt = S_MERGE_RD;
        end
      end
      S_MERGE_RD: begin
        fm_raddr  = mnode[WORD_LOG +: ROW_W];
        state_nxt = S_MERGE_CHK;
      end
      S_MERGE_CHK: begin
        fm_we    = 1'b1;
        fm_waddr = mnode[WORD_LOG +: ROW_W];
        fm_wdata = fm_rdata;
        if ((lvl_r < active_r) && fm_rdata[buddy[WORD_LOG-1:0]]) begin
          fm_wdata[mnode[WORD_LOG-1:0]] = 1'b0;
          fm_wdata[buddy[WORD_LOG-1:0]] = 1'b0;
          lvl_nxt   = lvl_r + LVL_BITS'(1);
          blk_nxt   = blk_r >> 1;
          state_nxt = S_MERGE_RD;
        end else begin
          fm_wdata[mnode[WORD_LOG-1:0]] = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_off_nxt    = res_off_r;
          out_lvl_nxt    = res_lvl_r;
          out_units_nxt  = UNITS_W'(count_r);
          pend_nxt       = 1'b0;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {5'b0, out_units_r, out_lvl_r, out_off_r};
endmodule

/* rtl/bba_checker.sv */
// Port-level checks for the buddy block allocator, bound to the top level.
module bba_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [3:0]  cfg_data,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [55:0] in_tdata,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [1:0]  out_tuser
);
  import bba_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[23:0] == 24'd0))
    else $error("failed result carries a grant");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second transfer taken while busy");

  a_reset_sweep: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !in_tready)
    else $error("input ready before clearing sweep");
endmodule

bind buddy_block_allocator bba_checker u_bba_checker (.*);

/* sim/buddy_block_allocator_tb.sv */
// Testbench for the buddy block allocator: directed and random allocate/free/clear traffic.
module buddy_block_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bba_pkg::*;

  localparam int MIN_BYTES = 1024;
  localparam int TOP_LVL   = 10;
  localparam int NODES     = 2 << TOP_LVL;
  localparam int UNITS     = 1 << TOP_LVL;
  localparam int WATCHDOG  = 20000;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OFFSET_W-1:0] goff;
    logic [GLEVEL_W-1:0] glvl;
    logic [UNITS_W-1:0]  units;
  } grant_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [55:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [1:0] out_tuser;

  bit free_bit[NODES];
  bit rec_ok[UNITS];
  int rec_lvl[UNITS];
  int alloc_units;
  int pool_reg;
  int act_lvl;
  int live_offs[$];

  grant_t grants_due[$];
  int errors = 0;
  int stall_cycles = 0;
  bit idle_on = 1'b1;
  bit hold_recv = 1'b0;
  int quiet = 0;

  buddy_block_allocator i_dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int node_idx(int lvl, int blk);
    return ((1 << (TOP_LVL - lvl)) + blk) & (NODES - 1);
  endfunction

  function automatic void pool_clear();
    foreach (free_bit[i]) free_bit[i] = 0;
    foreach (rec_ok[i]) begin
      rec_ok[i] = 0;
      rec_lvl[i] = 0;
    end
    alloc_units = 0;
    act_lvl = pool_reg > TOP_LVL ? TOP_LVL : pool_reg;
    free_bit[node_idx(act_lvl, 0)] = 1;
    live_offs.delete();
  endfunction

  function automatic grant_t predict_grant(logic [1:0] op, logic [31:0] sz, logic [19:0] off);
    grant_t g;
    longint pool_bytes;
    int want, lvl, blk, unit;
    bit found;
    g = '0;
    if (op == OP_ALLOC) begin
      pool_bytes = longint'(MIN_BYTES) << act_lvl;
      found = 0;
      if (longint'(sz) > pool_bytes) g.status = ST_TOO_BIG;
      else begin
        want = 0;
        while (want < act_lvl && (longint'(MIN_BYTES) << want) < longint'(sz)) want++;
        for (lvl = want; lvl <= act_lvl && !found; lvl++) begin
          for (blk = 0; blk < (1 << (act_lvl - lvl)); blk++)
            if (free_bit[node_idx(lvl, blk)]) begin
              found = 1;
              break;
            end
          if (found) break;
        end
        if (!found) g.status = ST_NO_BLOCK;
        else begin
          free_bit[node_idx(lvl, blk)] = 0;
          while (lvl > want) begin
            lvl--;
            blk <<= 1;
            free_bit[node_idx(lvl, blk + 1)] = 1;
          end
          unit = (blk << want) & (UNITS - 1);
          rec_ok[unit] = 1;
          rec_lvl[unit] = want;
          alloc_units += 1 << want;
          g.goff = 20'(unit * MIN_BYTES);
          g.glvl = 4'(want);
          live_offs.push_back(unit * MIN_BYTES);
        end
      end
    end else if (op == OP_FREE) begin
      unit = off / MIN_BYTES;
      if (off % MIN_BYTES != 0 || unit >= (1 << act_lvl) || !rec_ok[unit] ||
          rec_lvl[unit] > act_lvl) begin
        g.status = ST_BAD_FREE;
      end else begin
        lvl = rec_lvl[unit];
        rec_ok[unit] = 0;
        rec_lvl[unit] = 0;
        alloc_units -= 1 << lvl;
        blk = unit >> lvl;
        free_bit[node_idx(lvl, blk)] = 1;
        while (lvl < act_lvl && free_bit[node_idx(lvl, blk ^ 1)]) begin
          free_bit[node_idx(lvl, blk)] = 0;
          free_bit[node_idx(lvl, blk ^ 1)] = 0;
          lvl++;
          blk >>= 1;
          free_bit[node_idx(lvl, blk)] = 1;
        end
        foreach (live_offs[i])
          if (live_offs[i] == off) begin
            live_offs.delete(i);
            break;
          end
      end
    end else if (op == OP_CLEAR) begin
      pool_clear();
    end
    g.units = 11'(alloc_units);
    return g;
  endfunction

  task automatic idle_gap();
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 15)) @(negedge clk);
  endtask

  task automatic send_op(logic [1:0] op, logic [31:0] sz, logic [19:0] off);
    idle_gap();
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {4'b0, off, sz};
    do @(posedge clk); while (!in_tready);
    grants_due.push_back(predict_grant(op, sz, off));
    @(negedge clk);
    in_tvalid <= 1'b0;
  endtask

  task automatic drain();
    while (grants_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_pool(int lvl);
    drain();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= 4'(lvl);
    do @(posedge clk); while (!cfg_ready);
    pool_reg = lvl;
    @(negedge clk);
    cfg_valid <= 1'b0;
    send_op(OP_CLEAR, $urandom, 20'($urandom));
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  task automatic free_any();
    int k;
    if (live_offs.size() == 0) send_op(OP_FREE, $urandom, 20'($urandom_range(0, 1023) * 1024));
    else begin
      k = $urandom_range(0, live_offs.size() - 1);
      send_op(OP_FREE, $urandom, 20'(live_offs[k]));
    end
  endtask

  task automatic test_directed();
    send_op(OP_ALLOC, 32'd0, 20'd0);
    send_op(OP_ALLOC, 32'd1025, 20'hFFFFF);
    send_op(OP_ALLOC, 32'hFFFFFFFF, 20'd0);
    send_op(OP_ALLOC, 32'd1 << 20, 20'd0);
    send_op(OP_FREE, 32'd0, 20'd1);
    send_op(OP_FREE, 32'd0, 20'd4096);
    send_op(OP_FREE, 32'hFFFFFFFF, 20'hFFC00);
    send_op(OP_FREE, 32'd0, 20'd0);
    send_op(OP_FREE, 32'd0, 20'd2048);
    send_op(OP_UNUSED, 32'hA5A5A5A5, 20'h5A5A5);
    send_op(OP_ALLOC, 32'd1 << 19, 20'd0);
    send_op(OP_ALLOC, 32'd1 << 19, 20'd0);
    send_op(OP_ALLOC, 32'd1, 20'd0);
    send_op(OP_CLEAR, 32'd0, 20'd0);
    send_op(OP_ALLOC, 32'd1 << 20, 20'd0);
    send_op(OP_FREE, 32'd0, 20'd0);
  endtask

  task automatic test_pool_levels();
    set_pool(0);
    send_op(OP_ALLOC, 32'd1025, 20'd0);
    send_op(OP_ALLOC, 32'd1024, 20'd0);
    send_op(OP_ALLOC, 32'd1, 20'd0);
    send_op(OP_FREE, 32'd0, 20'd0);
    set_pool(15);
    send_op(OP_ALLOC, 32'd1 << 20, 20'd0);
    send_op(OP_FREE, 32'd0, 20'd0);
    set_pool(3);
    repeat (10) send_op(OP_ALLOC, $urandom_range(0, 3000), 20'd0);
    repeat (10) free_any();
  endtask

  task automatic test_backpressure();
    hold_recv = 1'b1;
    fork
      begin
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      repeat (6) send_op(OP_ALLOC, 32'd1, 20'd0);
    join
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if ($urandom_range(0, 3) == 0) send_op(OP_ALLOC, $urandom, 20'($urandom));
        else send_op(OP_ALLOC, $urandom_range(0, 1 << (act_lvl + 10)), 20'($urandom));
      end else if (r < 88) free_any();
      else if (r < 96) send_op(OP_FREE, $urandom, 20'($urandom));
      else if (r < 98) send_op(OP_UNUSED, $urandom, 20'($urandom));
      else send_op(OP_CLEAR, $urandom, 20'($urandom));
    end
  endtask

  always @(negedge clk) begin
    if (hold_recv) out_tready <= 1'b0;
    else if (stall_cycles > 0) begin
      out_tready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      stall_cycles <= $urandom_range(0, 14);
    end else out_tready <= 1'b1;
  end

  always @(posedge clk) begin
    grant_t g;
    if (out_tvalid && out_tready) begin
      if (grants_due.size() == 0) begin
        $display("unexpected transfer on result channel");
        errors++;
      end else begin
        g = grants_due.pop_front();
        if (out_tuser != g.status) report_mismatch("status", out_tuser, g.status);
        if (out_tdata[19:0] != g.goff) report_mismatch("offset", out_tdata[19:0], g.goff);
        if (out_tdata[23:20] != g.glvl) report_mismatch("level", out_tdata[23:20], g.glvl);
        if (out_tdata[34:24] != g.units) report_mismatch("units", out_tdata[34:24], g.units);
        if (out_tdata[39:35] != 0) report_mismatch("pad", out_tdata[39:35], 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || hold_recv)
      quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > WATCHDOG) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    pool_reg = 10;
    pool_clear();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_pool_levels();
    test_backpressure();
    set_pool(4);
    test_random(150);
    set_pool(10);
    test_random(200);
    set_pool(6);
    test_random(150);
    idle_on = 1'b0;
    test_random(80);
    drain();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule
